// ===== src/pprmw_pkg.sv =====
// Shared types and constants for the packed pixel read-modify-write engine.
// Holds the screen geometry, operation codes and the request/response payloads.
// No dependencies.
package pprmw_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int ROW_BYTES     = (SCREEN_WIDTH + 1) / 2;
    localparam int STORE_DEPTH   = SCREEN_HEIGHT * ROW_BYTES;
    localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    typedef enum logic [2:0] {
        OP_PLOT = 3'd0,
        OP_AND  = 3'd1,
        OP_OR   = 3'd2,
        OP_MIX  = 3'd3,
        OP_READ = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [3:0]        pixel_color;
        logic [3:0]        keep_mask;
    } req_t;

    typedef struct packed {
        logic [3:0] read_value;
        logic       clipped;
    } rsp_t;

endpackage

// ===== src/pprmw_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module pprmw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/packed_pixel_rmw_engine.sv =====
// Top level of the packed 4-bit-per-pixel read-modify-write engine.
// Depends on pprmw_pkg and pprmw_ram.
//
// The engine holds a framebuffer of two pixels per byte (odd x in the high nibble) in one
// block RAM and applies plot, AND, OR, mix or read to one pixel per transaction. Each
// request yields exactly one response. After reset the engine sweeps all STORE_DEPTH bytes
// (153600 at 640 x 480) of the RAM to zero, one byte per cycle, with req_stall held high
// throughout. A request then passes through address calculation, the RAM read and the
// modify-and-write-back, all on the one RAM port pair, with a single request in flight.
// A finished response waits in the output register, so the next request may be taken while
// it is still stalled.
module packed_pixel_rmw_engine
    import pprmw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MOD
    } state_t;

    state_t            state_reg, state_next;
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    logic [2:0]        op_reg, op_next;
    logic              hi_reg, hi_next;
    logic [3:0]        color_reg, color_next;
    logic [3:0]        mask_reg, mask_next;
    logic              clip_reg, clip_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              accept;
    logic              out_free;
    logic              x_in, y_in;
    logic [ADDR_W-1:0] addr_full;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic [7:0]        keep_other, color_sh, mask_sh, new_byte;
    logic [3:0]        pix_value;
    logic              do_write;

    assign req_stall = clearing_reg || (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // The sign bit is checked on its own, so the magnitude compare can be unsigned.
    assign x_in = !req.pos_x[11] && ({1'b0, req.pos_x[10:0]} < 12'(SCREEN_WIDTH));
    assign y_in = !req.pos_y[11] && ({1'b0, req.pos_y[10:0]} < 12'(SCREEN_HEIGHT));
    assign addr_full = ADDR_W'(req.pos_y[10:0]) * ADDR_W'(ROW_BYTES) +
                       ADDR_W'(req.pos_x[10:1]);

    // Nibble update for the byte read back from the RAM.
    always_comb
    begin
        keep_other = hi_reg ? 8'h0f : 8'hf0;
        color_sh   = hi_reg ? {color_reg, 4'h0} : {4'h0, color_reg};
        mask_sh    = hi_reg ? {mask_reg, 4'h0} : {4'h0, mask_reg};
        pix_value  = 4'h0;
        new_byte   = ram_rdata;
        do_write   = 1'b0;
        case (op_reg)
            OP_PLOT:
            begin
                new_byte = (ram_rdata & keep_other) | color_sh;
                do_write = 1'b1;
            end
            OP_AND:
            begin
                new_byte = ram_rdata & (color_sh | keep_other);
                do_write = 1'b1;
            end
            OP_OR:
            begin
                new_byte = ram_rdata | color_sh;
                do_write = 1'b1;
            end
            OP_MIX:
            begin
                new_byte = (ram_rdata & (mask_sh | keep_other)) | color_sh;
                do_write = 1'b1;
            end
            OP_READ:
            begin
                pix_value = hi_reg ? ram_rdata[7:4] : ram_rdata[3:0];
            end
            default:
            begin
                new_byte = ram_rdata;
            end
        endcase
    end

    assign ram_re    = (state_reg == S_READ) && !clip_reg;
    assign ram_we    = clearing_reg ||
                       ((state_reg == S_MOD) && out_free && !clip_reg && do_write);
    assign ram_waddr = clearing_reg ? clear_addr_reg : addr_reg;
    assign ram_wdata = clearing_reg ? 8'h00 : new_byte;

    always_comb
    begin
        state_next      = state_reg;
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        op_next         = op_reg;
        hi_next         = hi_reg;
        color_next      = color_reg;
        mask_next       = mask_reg;
        clip_next       = clip_reg;
        addr_next       = addr_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;

        if (clearing_reg)
        begin
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == ADDR_W'(STORE_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.op;
                    hi_next    = req.pos_x[0];
                    color_next = req.pixel_color;
                    mask_next  = req.keep_mask;
                    clip_next  = !(x_in && y_in);
                    addr_next  = addr_full;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                // The RAM holds its read data, so the write back can wait for the output slot.
                if (out_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.clipped   = clip_reg;
                    rsp_next.read_value = clip_reg ? 4'h0 : pix_value;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            op_reg         <= '0;
            hi_reg         <= 1'b0;
            color_reg      <= '0;
            mask_reg       <= '0;
            clip_reg       <= 1'b0;
            addr_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
            op_reg         <= op_next;
            hi_reg         <= hi_next;
            color_reg      <= color_next;
            mask_reg       <= mask_next;
            clip_reg       <= clip_next;
            addr_reg       <= addr_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_reg        <= rsp_next;
        end
    end

    pprmw_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_frame_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A clipped response never carries pixel data.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.clipped |-> rsp_reg.read_value == 4'h0)
        else $error("clipped response carries a non-zero pixel value");

    // The RAM is written only by the clearing sweep or at the end of a modify.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> clearing_reg || (state_reg == S_MOD))
        else $error("frame RAM written outside the clearing sweep or modify step");

    // A new response is only loaded from the modify step.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg ##1 rsp_valid_reg |-> $past(state_reg) == S_MOD)
        else $error("response appeared without a completed modify step");

    // No RAM read is issued while the clearing sweep is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !ram_re)
        else $error("frame RAM read during the clearing sweep");

endmodule

// ===== bench/tb_packed_pixel_rmw_engine.sv =====
// Self-checking testbench for packed_pixel_rmw_engine: directed and random pixel transactions,
// each predicted against a shadow copy of the 4-bit-per-pixel framebuffer.
// Depends on pprmw_pkg and the engine RTL only.
`timescale 1ns / 100ps

module tb_packed_pixel_rmw_engine;
    import pprmw_pkg::*;

    // Op codes the engine does not define; they must leave the store alone.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam int MAX_GAP         = 14;
    localparam int HOLD_CYCLES     = 150;
    localparam int REPORT_LIMIT    = 10;
    localparam int RANDOM_PHASES   = 7;
    localparam int PHASE_ITEMS     = 250;
    localparam int SETTLE_CYCLES   = 16;
    // The clearing sweep after reset keeps the input stalled over all STORE_DEPTH addresses.
    localparam int WATCHDOG_LIMIT  = 3 * STORE_DEPTH + 4000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic [7:0] shadow_frame [STORE_DEPTH];
    rsp_t       expected_pixels [$];

    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    int rx_hold_req = 0;
    int failures    = 0;
    int sent_count  = 0;
    int result_count  = 0;
    int read_count    = 0;
    int clipped_count = 0;
    int idle_cycles   = 0;

    packed_pixel_rmw_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        foreach (shadow_frame[i])
            shadow_frame[i] = 8'h00;
    end

    // Applies one pixel operation to the shadow framebuffer and returns its response.
    function automatic rsp_t apply_pixel_op(input req_t r);
        rsp_t        res;
        int          x;
        int          y;
        int unsigned addr;
        logic [7:0]  b;
        logic [7:0]  keep_other;
        logic [7:0]  color_lane;
        logic [7:0]  mask_lane;
        logic        hi;
        res = '0;
        x = $signed(r.pos_x);
        y = $signed(r.pos_y);
        res.clipped = (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT);
        if (!res.clipped)
        begin
            addr       = y * ROW_BYTES + (x >> 1);
            b          = shadow_frame[addr];
            hi         = x[0];
            keep_other = hi ? 8'h0f : 8'hf0;
            color_lane = hi ? {r.pixel_color, 4'h0} : {4'h0, r.pixel_color};
            mask_lane  = hi ? {r.keep_mask, 4'h0} : {4'h0, r.keep_mask};
            case (r.op)
                OP_PLOT: b = (b & keep_other) | color_lane;
                OP_AND:  b = b & (color_lane | keep_other);
                OP_OR:   b = b | color_lane;
                OP_MIX:  b = (b & (mask_lane | keep_other)) | color_lane;
                OP_READ: res.read_value = hi ? b[7:4] : b[3:0];
                default: ;
            endcase
            shadow_frame[addr] = b;
        end
        return res;
    endfunction

    function automatic req_t pixel_op(input logic [2:0] op, input int x, input int y,
                                      input logic [3:0] color, input logic [3:0] mask);
        req_t r;
        r.op          = op;
        r.pos_x       = 12'(x);
        r.pos_y       = 12'(y);
        r.pixel_color = color;
        r.keep_mask   = mask;
        return r;
    endfunction

    // Most transactions land in small windows so that read-modify-write hazards and reads
    // of earlier writes are frequent; the rest probe the borders and the full coordinate range.
    function automatic req_t random_pixel_op();
        req_t r;
        int   pick;
        int   bx;
        int   by;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            r.op = OP_READ;
        else if (pick < 95)
            r.op = 3'($urandom_range(OP_PLOT, OP_MIX));
        else
            r.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    bx = 0;
                    by = 0;
                end
                1:
                begin
                    bx = SCREEN_WIDTH - 8;
                    by = SCREEN_HEIGHT - 4;
                end
                default:
                begin
                    bx = SCREEN_WIDTH / 2;
                    by = SCREEN_HEIGHT / 2;
                end
            endcase
            r.pos_x = 12'(bx + $urandom_range(0, 7));
            r.pos_y = 12'(by + $urandom_range(0, 3));
        end
        else if (pick < 75)
        begin
            r.pos_x = 12'(($urandom_range(0, 1) ? SCREEN_WIDTH : 0) + $urandom_range(0, 3) - 2);
            r.pos_y = 12'(($urandom_range(0, 1) ? SCREEN_HEIGHT : 0) + $urandom_range(0, 3) - 2);
        end
        else
        begin
            r.pos_x = 12'($urandom);
            r.pos_y = 12'($urandom);
        end
        r.pixel_color = 4'($urandom);
        r.keep_mask   = 4'($urandom);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Offers one transaction after a random gap and records its prediction once accepted.
    task automatic send_pixel_op(input req_t item);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        expected_pixels.push_back(apply_pixel_op(item));
        sent_count++;
    endtask

    // Withdraws the offer so nothing is accepted twice, then waits for every response.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_pixels.size() != 0);
    endtask

    // Response side: compares each accepted transaction and drives the stall pattern.
    initial
    begin : result_check
        rsp_t want;
        int   stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                result_count++;
                if (expected_pixels.size() == 0)
                    note_failure($sformatf("unexpected response read_value=%h clipped=%b",
                                           rsp.read_value, rsp.clipped));
                else
                begin
                    want = expected_pixels.pop_front();
                    if (rsp.read_value !== want.read_value || rsp.clipped !== want.clipped)
                        note_failure($sformatf(
                            "response %0d: read_value exp %h got %h, clipped exp %b got %b",
                            result_count, want.read_value, rsp.read_value,
                            want.clipped, rsp.clipped));
                    if (want.clipped)
                        clipped_count++;
                    else if (want.read_value != 4'h0)
                        read_count++;
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (rx_hold_req > 0)
            begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Every operation on one byte, both nibbles, with read-back, plus the first and last unused op codes.
    task automatic test_pixel_ops();
        send_pixel_op(pixel_op(OP_PLOT, 2, 1, 4'ha, 4'h0));
        send_pixel_op(pixel_op(OP_PLOT, 3, 1, 4'h5, 4'hf));
        send_pixel_op(pixel_op(OP_READ, 2, 1, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_READ, 3, 1, 4'hf, 4'hf));
        send_pixel_op(pixel_op(OP_AND, 2, 1, 4'h6, 4'h0));
        send_pixel_op(pixel_op(OP_OR, 3, 1, 4'h8, 4'h0));
        send_pixel_op(pixel_op(OP_MIX, 2, 1, 4'h1, 4'hc));
        send_pixel_op(pixel_op(OP_READ, 2, 1, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_READ, 3, 1, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_SPARE_FIRST, 2, 1, 4'hf, 4'hf));
        send_pixel_op(pixel_op(OP_SPARE_LAST, 3, 1, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_READ, 2, 1, 4'h0, 4'h0));
    endtask

    // Just outside each border and at the coordinate extremes; nothing may wrap into the store.
    task automatic test_clipping();
        send_pixel_op(pixel_op(OP_PLOT, -1, 0, 4'hf, 4'h0));
        send_pixel_op(pixel_op(OP_PLOT, SCREEN_WIDTH, 0, 4'hf, 4'h0));
        send_pixel_op(pixel_op(OP_PLOT, 0, -1, 4'hf, 4'h0));
        send_pixel_op(pixel_op(OP_PLOT, 0, SCREEN_HEIGHT, 4'hf, 4'h0));
        send_pixel_op(pixel_op(OP_READ, -2048, -2048, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_READ, 2047, 2047, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_MIX, -2048, 2047, 4'hf, 4'hf));
        send_pixel_op(pixel_op(OP_SPARE_LAST, 2047, 0, 4'hf, 4'hf));
        send_pixel_op(pixel_op(OP_PLOT, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 4'hf, 4'hf));
        send_pixel_op(pixel_op(OP_READ, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_READ, SCREEN_WIDTH - 2, SCREEN_HEIGHT - 1, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_READ, 0, 0, 4'h0, 4'h0));
        send_pixel_op(pixel_op(OP_READ, 0, 1, 4'h0, 4'h0));
    endtask

    // The receiver holds off while transactions keep coming, so the engine must stall its
    // input; afterwards the sender waits until everything has drained.
    task automatic test_backpressure();
        int i;
        wait_for_results();
        tx_quiet    = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        for (i = 0; i < 10; i++)
            send_pixel_op(random_pixel_op());
        tx_quiet = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int phase;
        int i;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // The first phase runs flat out on both sides to expose forwarding hazards.
            tx_quiet = (phase == 0) || ($urandom_range(0, 3) == 0);
            rx_quiet = (phase == 0) || ($urandom_range(0, 3) == 0);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_pixel_op(random_pixel_op());
            if (phase % 3 == 2)
                wait_for_results();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timed out after %0d cycles without a transaction.", idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_pixel_ops();
        test_clipping();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            note_failure($sformatf("%0d responses never arrived", expected_pixels.size()));
        $display("Sent %0d pixel transactions, checked %0d responses, %0d failures.",
                 sent_count, result_count, failures);
        $display("Covered all ops incl. unused codes, %0d clipped, %0d nonzero reads.",
                 clipped_count, read_count);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/pprmw_pkg.sv
src/pprmw_ram.sv
src/packed_pixel_rmw_engine.sv
bench/tb_packed_pixel_rmw_engine.sv
